/* rtl/facd_pkg.sv */
// Package for the framed ASCII command decoder.
// Holds the shared types, character codes, register indexes and defaults.
// No dependencies.
`default_nettype none

package facd_pkg;

  // Default longest frame buffer, including the terminating slot
  localparam int CMD_LEN_DEFAULT = 32;

  // Configuration register file
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 1'd1;

  localparam logic [CFG_W-1:0] START_CHAR_RESET = 8'h23; // '#'
  localparam logic [CFG_W-1:0] END_CHAR_RESET   = 8'h0D; // CR

  // Command characters
  localparam logic [7:0] CHAR_O    = 8'h4F;
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] CHAR_NULL = 8'h00;

  typedef enum logic [1:0] {
    VERDICT_ON      = 2'd0,
    VERDICT_OFF     = 2'd1,
    VERDICT_UNKNOWN = 2'd2
  } verdict_t;

  // One result item
  typedef struct packed {
    verdict_t verdict;
    logic     led_on;
  } result_t;

  // Status from the decode core
  typedef struct packed {
    logic    result_valid;
    result_t result;
    logic    in_frame;
  } core_status_t;

endpackage

`default_nettype wire

/* rtl/facd_core.sv */
// Decode core: frame tracking and incremental match flags for ON and OFF.
// Depends on facd_pkg.
`default_nettype none

module facd_core #(
  parameter int CMD_LEN = facd_pkg::CMD_LEN_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,    // process byte_in this cycle
  input  wire logic [7:0]                  byte_in,
  input  wire logic [facd_pkg::CFG_W-1:0]  start_char,
  input  wire logic [facd_pkg::CFG_W-1:0]  end_char,
  output facd_pkg::core_status_t           status
);

  localparam int CNT_W = $clog2(CMD_LEN);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CMD_LEN - 1);

  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic             text_ended, text_ended_next;
  logic             match_on, match_on_next;
  logic             match_off, match_off_next;
  logic             led_state, led_state_next;
  logic             is_start, is_end, keep;
  logic             pos_is2, pos_is3;
  logic             byte_on_ok, byte_off_ok;
  logic             res_valid;
  facd_pkg::verdict_t verdict;

  assign is_start = (byte_in == start_char);
  assign is_end   = (byte_in == end_char);
  assign keep     = in_frame && !is_start && !is_end && (stored_count < CNT_LIMIT);
  assign pos_is2  = (stored_count == CNT_W'(2));
  assign pos_is3  = (stored_count == CNT_W'(3));

  // Character at the current position against each command word
  always_comb begin
    byte_on_ok  = 1'b0;
    byte_off_ok = 1'b0;
    if (stored_count == CNT_W'(0)) begin
      byte_on_ok  = (byte_in == facd_pkg::CHAR_O);
      byte_off_ok = (byte_in == facd_pkg::CHAR_O);
    end else if (stored_count == CNT_W'(1)) begin
      byte_on_ok  = (byte_in == facd_pkg::CHAR_N);
      byte_off_ok = (byte_in == facd_pkg::CHAR_F);
    end else if (pos_is2) begin
      byte_off_ok = (byte_in == facd_pkg::CHAR_F);
    end
  end

  // Next state and result
  always_comb begin
    in_frame_next     = in_frame;
    stored_count_next = stored_count;
    text_ended_next   = text_ended;
    match_on_next     = match_on;
    match_off_next    = match_off;
    led_state_next    = led_state;
    res_valid         = 1'b0;
    verdict           = facd_pkg::VERDICT_UNKNOWN;
    if (is_start) begin
      in_frame_next     = 1'b1;
      stored_count_next = '0;
      text_ended_next   = 1'b0;
      match_on_next     = 1'b1;
      match_off_next    = 1'b1;
    end else if (in_frame && is_end) begin
      in_frame_next = 1'b0;
      res_valid     = 1'b1;
      if (match_on && (text_ended || pos_is2)) begin
        led_state_next = 1'b1;
        verdict        = facd_pkg::VERDICT_ON;
      end else if (match_off && (text_ended || pos_is3)) begin
        led_state_next = 1'b0;
        verdict        = facd_pkg::VERDICT_OFF;
      end
    end else if (keep) begin
      stored_count_next = stored_count + CNT_W'(1);
      if (!text_ended) begin
        if (byte_in == facd_pkg::CHAR_NULL) begin
          text_ended_next = 1'b1;
          match_on_next   = match_on && pos_is2;
          match_off_next  = match_off && pos_is3;
        end else begin
          match_on_next  = match_on && byte_on_ok;
          match_off_next = match_off && byte_off_ok;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      stored_count <= '0;
      text_ended   <= 1'b0;
      match_on     <= 1'b1;
      match_off    <= 1'b1;
      led_state    <= 1'b0;
    end else if (advance) begin
      in_frame     <= in_frame_next;
      stored_count <= stored_count_next;
      text_ended   <= text_ended_next;
      match_on     <= match_on_next;
      match_off    <= match_off_next;
      led_state    <= led_state_next;
    end
  end

  assign status.result_valid   = res_valid;
  assign status.result.verdict = verdict;
  assign status.result.led_on  = led_state_next;
  assign status.in_frame       = in_frame;

endmodule

`default_nettype wire

/* rtl/facd_out_reg.sv */
// Result register on the master side of the decoder.
// Depends on facd_pkg.
`default_nettype none

module facd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  facd_pkg::result_t      result_in,
  output logic                   can_load,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata    // [1:0] verdict, [2] led_on
);

  logic              out_valid;
  facd_pkg::result_t out_data;

  // Free when empty or being drained this cycle
  assign can_load = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result_in;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.led_on, out_data.verdict};

endmodule

`default_nettype wire

/* rtl/framed_ascii_command_decoder.sv */
// Framed ASCII command decoder, top level: input register, decode core, result register.
// Path: input register, then result register; one byte per cycle unless a result waits.
// The input register and the decode core advance together whenever the result register
// is empty or being drained, so a stalled master stops intake only while a result waits.
// Reset (rst, synchronous): no frame open, LED off, start '#' and end CR restored.
// Depends on facd_pkg, facd_core, facd_out_reg.
`default_nettype none

module framed_ascii_command_decoder #(
  parameter int CMD_LEN = facd_pkg::CMD_LEN_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,    // [7:0] rx_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,    // [1:0] verdict, [2] led_on
  input  wire logic                          cfg_we,
  input  wire logic [facd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [facd_pkg::CFG_W-1:0]    cfg_data
);

  logic [facd_pkg::CFG_W-1:0] start_char, end_char;
  logic                       byte_valid;
  logic [7:0]                 byte_q;
  logic                       advance, out_free, load;
  facd_pkg::core_status_t     status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= facd_pkg::START_CHAR_RESET;
      end_char   <= facd_pkg::END_CHAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        facd_pkg::CFG_START_CHAR: start_char <= cfg_data;
        facd_pkg::CFG_END_CHAR:   end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign advance  = byte_valid && out_free;
  assign s_tready = !byte_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tready) begin
      byte_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_q <= s_tdata;
    end
  end

  facd_core #(
    .CMD_LEN (CMD_LEN)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .byte_in    (byte_q),
    .start_char (start_char),
    .end_char   (end_char),
    .status     (status)
  );

  assign load = advance && status.result_valid;

  facd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result_in (status.result),
    .can_load  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A result closes the frame
  assert property (@(posedge clk) disable iff (rst) load |=> !status.in_frame)
    else $error("frame still open after a result");

  // A start byte always opens a frame
  assert property (@(posedge clk) disable iff (rst)
    (advance && (byte_q == start_char)) |=> status.in_frame)
    else $error("start byte did not open a frame");

  // Verdict and LED state agree
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == facd_pkg::VERDICT_ON && m_tdata[2]) ||
                  (m_tdata[1:0] == facd_pkg::VERDICT_OFF && !m_tdata[2]) ||
                  (m_tdata[1:0] == facd_pkg::VERDICT_UNKNOWN)))
    else $error("verdict and LED state disagree");

endmodule

`default_nettype wire
